FILE: design/lzw_variable_width_decoder_top_macros.svh
// Assertion macros used by the LZW decoder datapath.
// Depends on nothing; the assertions compile away when SYNTHESIS is defined.
`ifndef LZW_VARIABLE_WIDTH_DECODER_TOP_MACROS_SVH
`define LZW_VARIABLE_WIDTH_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante
`define LZW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that cons holds in the cycle after ante
`define LZW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LZW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LZW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/lzw_pkg.sv
// Types, codes and constants of the LZW decoder.
// Used by the controller, the datapath and the top level.
package lzw_pkg;

   localparam int MAX_CODE_BITS_DEF = 12;
   localparam int STACK_DEPTH_DEF   = 4096;

   localparam int ACC_W  = 32;
   localparam int CNT_W  = 6;
   localparam int BYTE_W = 8;

   localparam int CODE_CLEAR = 'h100;
   localparam int CODE_END   = 'h101;
   localparam int FIRST_FREE = 'h102;
   localparam int LIT_MAX    = 'hff;
   localparam int MIN_WIDTH  = 9;

   localparam logic CMD_SUPPLY = 1'b0;
   localparam logic CMD_PULL   = 1'b1;

   localparam logic [2:0] ST_BYTE     = 3'd0;
   localparam logic [2:0] ST_ACCEPTED = 3'd1;
   localparam logic [2:0] ST_NEED     = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_ENDED    = 3'd4;
   localparam logic [2:0] ST_ERROR    = 3'd5;

   typedef struct packed {
      logic               command;
      logic [BYTE_W-1:0]  data_byte;
   } lzw_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [BYTE_W-1:0]  out_byte;
      logic               string_end;
   } lzw_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_WALK, S_FIX, S_EMIT
   } lzw_state_type;

   // Outcome of the code at the bottom of the accumulator
   typedef enum logic [2:0] {
      DK_NEED, DK_FAIL, DK_LITERAL, DK_CLEAR, DK_END, DK_CHAIN, DK_KWK
   } lzw_kind_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_SUPPLY, OP_POP, OP_DECODE, OP_WALK, OP_FIX, OP_EMIT
   } lzw_op_type;

   typedef struct packed {
      lzw_op_type  op;
      logic        set_status;
      logic [2:0]  status;
   } lzw_cmd_type;

   typedef struct packed {
      logic          level_zero;
      logic          error;
      logic          ended;
      logic          full;
      lzw_kind_type  kind;
      logic          walk_last;
      logic          walk_fail;
      logic          kwk;
      logic          out_free;
   } lzw_stat_type;

endpackage

FILE: design/lzw_dpath.sv
// Datapath of the LZW decoder: bit accumulator, dictionary, output stack, result register.
// Depends on lzw_pkg and the assertion macros header.
`include "lzw_variable_width_decoder_top_macros.svh"
module lzw_dpath #(
   parameter int MAX_CODE_BITS = lzw_pkg::MAX_CODE_BITS_DEF,
   parameter int STACK_DEPTH   = lzw_pkg::STACK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lzw_pkg::lzw_req_type req_data,
   input  lzw_pkg::lzw_cmd_type cmd,
   output lzw_pkg::lzw_stat_type stat,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output lzw_pkg::lzw_rsp_type rsp_data
);
   import lzw_pkg::*;

   localparam int DICT = 1 << MAX_CODE_BITS;
   localparam int CW   = MAX_CODE_BITS;
   localparam int NW   = MAX_CODE_BITS + 1;
   localparam int WW   = $clog2(MAX_CODE_BITS + 1);
   localparam int LW   = $clog2(STACK_DEPTH + 1);
   localparam int SA   = $clog2(STACK_DEPTH);

   // State registers
   logic [ACC_W-1:0]  acc_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WW-1:0]     width_ff;
   logic [NW-1:0]     nfc_ff;
   logic [CW-1:0]     prev_ff;
   logic [LW-1:0]     level_ff;
   logic              started_ff, literal_ff, ended_ff, error_ff;
   logic              pend_ff;
   logic              rsp_valid_ff;

   // Payload registers
   logic [CW-1:0]     walk_code_ff, code_ff;
   logic              kwk_ff;
   logic [BYTE_W-1:0] first_ff;
   logic [2:0]        status_ff;
   lzw_rsp_type       rsp_ff;

   // Memories
   logic [BYTE_W-1:0] suffix_mem [DICT];
   logic [CW-1:0]     prefix_mem [DICT];
   logic [BYTE_W-1:0] stack_mem  [STACK_DEPTH];
   logic [BYTE_W-1:0] suffix_q, stack_q;
   logic [CW-1:0]     prefix_q;

   logic [ACC_W-1:0]  mask32, code_full;
   logic [CW-1:0]     code;
   logic [NW-1:0]     code_ext, nfc_inc;
   logic              have_bits, grow, width_ok;
   lzw_kind_type      kind;
   logic [CW-1:0]     cur;
   logic              cur_long, walk_last, push_now, overflow, add_now;
   logic [BYTE_W-1:0] push_val;
   logic [LW-1:0]     lvl_dec;
   logic              st_we;
   logic [SA-1:0]     st_waddr;
   logic [BYTE_W-1:0] st_wdata;
   logic              dict_re;

   // Extract and classify the next code
   always_comb begin
      mask32    = (ACC_W'(1) << width_ff) - ACC_W'(1);
      code_full = acc_ff & mask32;
      code      = code_full[CW-1:0];
      code_ext  = NW'(code);
      have_bits = cnt_ff >= CNT_W'(width_ff);
      width_ok  = (width_ff >= WW'(MIN_WIDTH)) && (width_ff <= WW'(MAX_CODE_BITS));
      if (!have_bits) begin
         kind = DK_NEED;
      end else if (!started_ff && code != CW'(CODE_CLEAR)) begin
         kind = DK_FAIL;
      end else if (literal_ff) begin
         kind = (code > CW'(LIT_MAX)) ? DK_FAIL : DK_LITERAL;
      end else if (code == CW'(CODE_CLEAR)) begin
         kind = DK_CLEAR;
      end else if (code == CW'(CODE_END)) begin
         kind = DK_END;
      end else if (code_ext < nfc_ff) begin
         kind = DK_CHAIN;
      end else if (code_ext == nfc_ff) begin
         kind = DK_KWK;
      end else begin
         kind = DK_FAIL;
      end
   end

   // Prefix chain walk: push the last read's suffix or the final literal, dictionary read fed from the last read
   always_comb begin
      cur       = pend_ff ? prefix_q : walk_code_ff;
      cur_long  = cur > CW'(LIT_MAX);
      walk_last = !pend_ff && !(walk_code_ff > CW'(LIT_MAX));
      push_now  = pend_ff || walk_last;
      push_val  = pend_ff ? suffix_q : walk_code_ff[BYTE_W-1:0];
      overflow  = push_now && (level_ff >= LW'(STACK_DEPTH));
      add_now   = (cmd.op == OP_WALK) && !overflow && walk_last && !nfc_ff[CW];
      dict_re   = (cmd.op == OP_WALK) && !overflow && cur_long;
      nfc_inc   = nfc_ff + NW'(1);
      grow      = (nfc_inc == (NW'(1) << width_ff)) && (width_ff < WW'(MAX_CODE_BITS));
      lvl_dec   = level_ff - LW'(1);
   end

   // Select the stack write
   always_comb begin
      st_we    = 1'b0;
      st_waddr = level_ff[SA-1:0];
      st_wdata = push_val;
      case (cmd.op)
         OP_DECODE: begin
            if (kind == DK_LITERAL) begin
               st_we    = 1'b1;
               st_waddr = '0;
               st_wdata = code[BYTE_W-1:0];
            end
         end
         OP_WALK: begin
            st_we = push_now && !overflow;
         end
         OP_FIX: begin
            st_we    = 1'b1;
            st_waddr = '0;
            st_wdata = first_ff;
         end
         default: begin
            st_we = 1'b0;
         end
      endcase
   end

   // Dictionary: one write, one registered read
   always_ff @(posedge clock) begin
      if (add_now) begin
         suffix_mem[nfc_ff[CW-1:0]] <= walk_code_ff[BYTE_W-1:0];
         prefix_mem[nfc_ff[CW-1:0]] <= prev_ff;
      end
      if (dict_re) begin
         suffix_q <= suffix_mem[cur];
         prefix_q <= prefix_mem[cur];
      end
   end

   // Output stack: one write, one registered read
   always_ff @(posedge clock) begin
      if (st_we) begin
         stack_mem[st_waddr] <= st_wdata;
      end
      if (cmd.op == OP_POP) begin
         stack_q <= stack_mem[lvl_dec[SA-1:0]];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         width_ff     <= WW'(MIN_WIDTH);
         nfc_ff       <= NW'(FIRST_FREE);
         prev_ff      <= '0;
         level_ff     <= '0;
         started_ff   <= 1'b0;
         literal_ff   <= 1'b0;
         ended_ff     <= 1'b0;
         error_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise the result beat on emit, drop it once taken
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_SUPPLY: begin
               if (!error_ff && !ended_ff && !stat.full) begin
                  acc_ff <= acc_ff | (ACC_W'(req_data.data_byte) << cnt_ff);
                  cnt_ff <= cnt_ff + CNT_W'(BYTE_W);
               end
            end
            OP_POP: begin
               level_ff <= lvl_dec;
            end
            OP_DECODE: begin
               if (kind != DK_NEED) begin
                  acc_ff <= acc_ff >> width_ff;
                  cnt_ff <= cnt_ff - CNT_W'(width_ff);
                  if (!started_ff && code == CW'(CODE_CLEAR)) begin
                     started_ff <= 1'b1;
                  end
               end
               case (kind)
                  DK_FAIL: begin
                     error_ff <= 1'b1;
                     level_ff <= '0;
                  end
                  DK_LITERAL: begin
                     literal_ff <= 1'b0;
                     prev_ff    <= code;
                     level_ff   <= LW'(1);
                  end
                  DK_CLEAR: begin
                     width_ff   <= WW'(MIN_WIDTH);
                     nfc_ff     <= NW'(FIRST_FREE);
                     literal_ff <= 1'b1;
                  end
                  DK_END: begin
                     ended_ff <= 1'b1;
                  end
                  DK_CHAIN: begin
                     pend_ff <= 1'b0;
                  end
                  DK_KWK: begin
                     // reserve the bottom slot for the trailing byte
                     level_ff <= LW'(1);
                     pend_ff  <= 1'b0;
                  end
                  default: begin
                     pend_ff <= pend_ff;
                  end
               endcase
            end
            OP_WALK: begin
               if (overflow) begin
                  error_ff <= 1'b1;
                  level_ff <= '0;
                  pend_ff  <= 1'b0;
               end else begin
                  if (push_now) begin
                     level_ff <= level_ff + LW'(1);
                  end
                  pend_ff <= cur_long;
                  if (walk_last) begin
                     prev_ff <= code_ff;
                  end
                  if (add_now) begin
                     nfc_ff <= nfc_inc;
                     if (grow) begin
                        width_ff <= width_ff + WW'(1);
                     end
                  end
               end
            end
            default: begin
               pend_ff <= pend_ff;
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.op == OP_DECODE && kind == DK_CHAIN) begin
         walk_code_ff <= code;
         code_ff      <= code;
         kwk_ff       <= 1'b0;
      end else if (cmd.op == OP_DECODE && kind == DK_KWK) begin
         walk_code_ff <= prev_ff;
         code_ff      <= code;
         kwk_ff       <= 1'b1;
      end else if (cmd.op == OP_WALK) begin
         walk_code_ff <= cur;
      end
      if (cmd.op == OP_WALK && walk_last) begin
         first_ff <= walk_code_ff[BYTE_W-1:0];
      end
      if (cmd.op == OP_EMIT) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.out_byte   <= (status_ff == ST_BYTE) ? stack_q : '0;
         rsp_ff.string_end <= (status_ff == ST_BYTE) && (level_ff == '0);
      end
   end

   // Status to the controller
   always_comb begin
      stat.level_zero = level_ff == '0;
      stat.error      = error_ff;
      stat.ended      = ended_ff;
      stat.full       = cnt_ff > CNT_W'(ACC_W - BYTE_W);
      stat.kind       = kind;
      stat.walk_last  = walk_last;
      stat.walk_fail  = overflow;
      stat.kwk        = kwk_ff;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LZW_ASSERT_IMP(a_level_bound, clock, reset, 1'b1, level_ff <= LW'(STACK_DEPTH), "overrun")
   `LZW_ASSERT_IMP(a_error_empty, clock, reset, error_ff, level_ff == '0, "stack left after error")
   `LZW_ASSERT_IMP(a_width_range, clock, reset, 1'b1, width_ok, "code width out of range")
   `LZW_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.op == OP_EMIT, rsp_valid_ff, "beat lost")

endmodule

FILE: design/lzw_ctrl.sv
// Controller state machine of the LZW decoder: sequences supply, decode, walk, fix, pop and emit.
// Depends on lzw_pkg.
module lzw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  lzw_pkg::lzw_stat_type stat,
   output lzw_pkg::lzw_cmd_type  cmd
);
   import lzw_pkg::*;

   lzw_state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.op         = OP_NONE;
      cmd.set_status = 1'b0;
      cmd.status     = ST_BYTE;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_SUPPLY) begin
                  cmd.op         = OP_SUPPLY;
                  cmd.set_status = 1'b1;
                  if (stat.error) begin
                     cmd.status = ST_ERROR;
                  end else if (stat.ended) begin
                     cmd.status = ST_ENDED;
                  end else if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.status = ST_ACCEPTED;
                  end
                  state_in = S_EMIT;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            cmd.set_status = 1'b1;
            if (!stat.level_zero) begin
               cmd.op     = OP_POP;
               cmd.status = ST_BYTE;
               state_in   = S_EMIT;
            end else if (stat.error) begin
               cmd.status = ST_ERROR;
               state_in   = S_EMIT;
            end else if (stat.ended) begin
               cmd.status = ST_ENDED;
               state_in   = S_EMIT;
            end else begin
               cmd.op = OP_DECODE;
               case (stat.kind)
                  DK_NEED: begin
                     cmd.status = ST_NEED;
                     state_in   = S_EMIT;
                  end
                  DK_FAIL: begin
                     cmd.status = ST_ERROR;
                     state_in   = S_EMIT;
                  end
                  DK_END: begin
                     cmd.status = ST_ENDED;
                     state_in   = S_EMIT;
                  end
                  DK_CHAIN, DK_KWK: begin
                     state_in = S_WALK;
                  end
                  default: begin
                     state_in = S_DECIDE;
                  end
               endcase
            end
         end
         S_WALK: begin
            cmd.op = OP_WALK;
            if (stat.walk_fail) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_ERROR;
               state_in       = S_EMIT;
            end else if (stat.walk_last) begin
               state_in = stat.kwk ? S_FIX : S_DECIDE;
            end
         end
         S_FIX: begin
            cmd.op   = OP_FIX;
            state_in = S_DECIDE;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: design/lzw_variable_width_decoder_top.sv
// LZW decoder, 9 to MAX_CODE_BITS bit codes, one beat in flight at a time.
// Supply beat: S_IDLE registers its status, S_EMIT the result once the output is free.
// Pull with bytes on the stack: S_DECIDE pops a byte, S_EMIT registers the result.
// Each code a pull decodes passes S_DECIDE; a chain or KwKwK code then walks its prefix
// links in S_WALK, and a KwKwK code goes on to S_FIX to fill the last byte of its string.
// Synchronous active-high reset clears control state; dictionary and stack are not cleared.
module lzw_variable_width_decoder_top #(
   parameter int MAX_CODE_BITS = lzw_pkg::MAX_CODE_BITS_DEF,
   parameter int STACK_DEPTH   = lzw_pkg::STACK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lzw_pkg::lzw_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lzw_pkg::lzw_rsp_type rsp_data
);
   import lzw_pkg::*;

   lzw_cmd_type  cmd;
   lzw_stat_type stat;

   // Sequence the work
   lzw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_data.command),
      .stat        (stat),
      .cmd         (cmd)
   );

   // Hold the stream state and storage
   lzw_dpath #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .STACK_DEPTH   (STACK_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: dv/testbench.sv
// Testbench for the LZW variable-width decoder: encodes directed and random streams into
// LSB-first codes, drives supply and pull beats, and checks each result.
// Depends on lzw_pkg and lzw_variable_width_decoder_top.
`timescale 1ns / 100ps

// Predicts the decoder's answer to each beat and checks results in order
class lzw_scoreboard;
   bit [31:0] acc;
   int unsigned acc_bits, width, free_code, last_code, level;
   bit [7:0]  tail_byte[4096];
   bit [11:0] link_code[4096];
   bit [7:0]  out_bytes[4096];
   bit started, want_literal, ended, broken;
   lzw_pkg::lzw_rsp_type waiting[$];
   int failures;
   int seen[8];

   function new();
      acc = 0; acc_bits = 0; width = lzw_pkg::MIN_WIDTH;
      free_code = lzw_pkg::FIRST_FREE; last_code = 0; level = 0;
      started = 0; want_literal = 0; ended = 0; broken = 0; failures = 0;
   endfunction

   function bit push_out(bit [7:0] b);
      if (level >= 4096) return 0;
      out_bytes[level] = b;
      level++;
      return 1;
   endfunction

   // Walk a code's prefix links, pushing its bytes last first
   function bit push_string(int unsigned code);
      code &= 4095;
      while (code > lzw_pkg::LIT_MAX) begin
         if (!push_out(tail_byte[code])) return 0;
         code = link_code[code];
      end
      return push_out(code[7:0]);
   endfunction

   function void grow_table(bit [7:0] first, int unsigned pre);
      if (free_code >= 4096) return;
      tail_byte[free_code] = first;
      link_code[free_code] = pre[11:0];
      free_code++;
      if (free_code >= (1 << width) && width < 12) width++;
   endfunction

   function logic [2:0] give_up();
      broken = 1;
      level = 0;
      return lzw_pkg::ST_ERROR;
   endfunction

   function logic [2:0] decode_code();
      int unsigned code;
      bit [7:0] first;
      if (acc_bits < width) return lzw_pkg::ST_NEED;
      code = acc & ((1 << width) - 1);
      acc = acc >> width;
      acc_bits -= width;
      if (!started) begin
         if (code != lzw_pkg::CODE_CLEAR) return give_up();
         started = 1;
      end
      if (want_literal) begin
         if (code > lzw_pkg::LIT_MAX) return give_up();
         want_literal = 0;
         last_code = code;
         void'(push_out(code[7:0]));
         return lzw_pkg::ST_BYTE;
      end
      if (code == lzw_pkg::CODE_CLEAR) begin
         width = lzw_pkg::MIN_WIDTH;
         free_code = lzw_pkg::FIRST_FREE;
         want_literal = 1;
         return lzw_pkg::ST_BYTE;
      end
      if (code == lzw_pkg::CODE_END) begin
         ended = 1;
         return lzw_pkg::ST_ENDED;
      end
      if (code < free_code) begin
         if (!push_string(code)) return give_up();
         first = out_bytes[level-1];
      end else begin
         if (code != free_code) return give_up();
         // trailing byte repeats the first one: fill the bottom slot afterwards
         void'(push_out(0));
         if (!push_string(last_code)) return give_up();
         first = out_bytes[level-1];
         out_bytes[0] = first;
      end
      grow_table(first, last_code);
      last_code = code & 4095;
      return lzw_pkg::ST_BYTE;
   endfunction

   // Note an accepted beat; returns the answer it should get
   function lzw_pkg::lzw_rsp_type note_beat(lzw_pkg::lzw_req_type r);
      lzw_pkg::lzw_rsp_type e;
      e = '0;
      e.status = lzw_pkg::ST_BYTE;
      if (r.command == lzw_pkg::CMD_SUPPLY) begin
         if (broken) e.status = lzw_pkg::ST_ERROR;
         else if (ended) e.status = lzw_pkg::ST_ENDED;
         else if (acc_bits + 8 > 32) e.status = lzw_pkg::ST_FULL;
         else begin
            acc |= 32'(r.data_byte) << acc_bits;
            acc_bits += 8;
            e.status = lzw_pkg::ST_ACCEPTED;
         end
      end else begin
         while (level == 0 && e.status == lzw_pkg::ST_BYTE) begin
            if (broken) e.status = lzw_pkg::ST_ERROR;
            else if (ended) e.status = lzw_pkg::ST_ENDED;
            else e.status = decode_code();
         end
         if (e.status == lzw_pkg::ST_BYTE) begin
            level--;
            e.out_byte = out_bytes[level];
            e.string_end = (level == 0);
         end
      end
      seen[e.status]++;
      waiting.push_back(e);
      return e;
   endfunction

   function void check_result(lzw_pkg::lzw_rsp_type got);
      lzw_pkg::lzw_rsp_type e;
      if (waiting.size() == 0) begin
         $display("%t: unexpected result %p", $realtime, got);
         failures++;
         return;
      end
      e = waiting.pop_front();
      if (got.status !== e.status) begin
         $display("%t: status expected %0d actual %0d", $realtime, e.status, got.status);
         failures++;
      end
      if (got.out_byte !== e.out_byte) begin
         $display("%t: out_byte expected %h actual %h", $realtime, e.out_byte, got.out_byte);
         failures++;
      end
      if (got.string_end !== e.string_end) begin
         $display("%t: string_end expected %b actual %b", $realtime, e.string_end,
                  got.string_end);
         failures++;
      end
   endfunction
endclass

module testbench;
   import lzw_pkg::*;

   localparam int STALL_LIMIT = 50000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   lzw_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   lzw_rsp_type rsp_data;

   lzw_scoreboard board = new();
   bit steady = 0;
   int quiet_cycles = 0;

   // Compressed stream and the bit packer feeding it
   bit [7:0] packed_bytes[$];
   bit [63:0] pack_buf = 0;
   int pack_bits = 0;
   int dec_free = FIRST_FREE;
   int dec_width = MIN_WIDTH;
   bit lit_next = 0;

   lzw_variable_width_decoder_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Pack one code at the width the decoder will read it with
   task automatic put_code(int code);
      pack_buf |= 64'(code) << pack_bits;
      pack_bits += dec_width;
      while (pack_bits >= 8) begin
         packed_bytes.push_back(pack_buf[7:0]);
         pack_buf = pack_buf >> 8;
         pack_bits -= 8;
      end
      if (code == CODE_CLEAR) begin
         dec_free = FIRST_FREE;
         dec_width = MIN_WIDTH;
         lit_next = 1;
      end else if (lit_next) begin
         lit_next = 0;
      end else if (code != CODE_END && dec_free < 4096) begin
         dec_free++;
         if (dec_free >= (1 << dec_width) && dec_width < 12) dec_width++;
      end
   endtask

   // Encode one cleared segment of plain bytes
   task automatic encode_run(bit [7:0] plain[$]);
      int strings[int];
      int enc_next;
      int cur;
      int key;
      enc_next = FIRST_FREE;
      put_code(CODE_CLEAR);
      cur = plain[0];
      for (int i = 1; i < plain.size(); i++) begin
         key = cur * 256 + plain[i];
         if (strings.exists(key)) cur = strings[key];
         else begin
            put_code(cur);
            if (enc_next < 4096) strings[key] = enc_next++;
            cur = plain[i];
         end
      end
      put_code(cur);
   endtask

   task automatic random_run(int len, int alphabet);
      bit [7:0] plain[$];
      bit [7:0] base;
      base = 8'($urandom);
      for (int i = 0; i < len; i++) begin
         plain.push_back(8'(base + $urandom_range(alphabet - 1)));
      end
      encode_run(plain);
   endtask

   // Send one beat, idling first at random; valid stays high between back-to-back beats
   task automatic send_beat(logic cmd, logic [7:0] b, output lzw_rsp_type e);
      lzw_req_type r;
      r.command = cmd;
      r.data_byte = b;
      if (!steady && $urandom_range(99) < 35) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      e = board.note_beat(r);
   endtask

   task automatic pull_byte();
      lzw_rsp_type e;
      send_beat(CMD_PULL, 8'($urandom), e);
   endtask

   // Supply the next packed byte; advance only when it was taken
   task automatic supply_next(inout int pos);
      lzw_rsp_type e;
      send_beat(CMD_SUPPLY, packed_bytes[pos], e);
      if (e.status == ST_ACCEPTED) pos++;
   endtask

   // Result side: stall at random, check every accepted result
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         rsp_ready <= steady || ($urandom_range(99) >= 35);
      end
   end

   // Watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("lzw_variable_width_decoder_top: mismatch");
         $finish;
      end
   end

   initial begin
      bit [7:0] plain[$];
      int pos;
      int beats;
      int ending;
      lzw_rsp_type e;
      pos = 0;
      beats = 0;

      // Directed: repeated pattern hits the KwKwK case, then extreme literals, then a run of one byte
      plain = '{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41};
      encode_run(plain);
      plain = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff};
      encode_run(plain);
      plain = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61};
      encode_run(plain);
      // Random segments, one long enough to widen the codes past nine bits
      for (int s = 0; s < 3; s++) random_run($urandom_range(20, 50), $urandom_range(2, 256));
      random_run(270, 256);
      random_run(40, 3);
      for (int s = 0; s < 2; s++) random_run($urandom_range(20, 50), $urandom_range(2, 256));
      // Close with a stop code, a literal above a byte, or a code past the free one
      ending = $urandom_range(2);
      if (ending == 0) put_code(CODE_END);
      else if (ending == 1) begin
         put_code(CODE_CLEAR);
         put_code('h1ff);
      end else begin
         put_code(CODE_CLEAR);
         put_code('h5a);
         put_code(FIRST_FREE + 5);
      end
      if (pack_bits > 0) packed_bytes.push_back(pack_buf[7:0]);

      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Pull with nothing supplied, then overfill the accumulator
      pull_byte();
      repeat (5) supply_next(pos);

      // Mixed supply and pull until the stream is in
      while (pos < packed_bytes.size()) begin
         beats++;
         steady <= (beats >= 300 && beats < 550);
         if ($urandom_range(1)) supply_next(pos);
         else pull_byte();
      end
      steady <= 0;
      // Drain, then poke the stopped decoder from both sides
      do send_beat(CMD_PULL, 8'($urandom), e); while (e.status == ST_BYTE);
      for (int i = 0; i < 6; i++) begin
         send_beat(i[0] ? CMD_PULL : CMD_SUPPLY, 8'($urandom), e);
      end
      req_valid <= 0;

      while (board.waiting.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d stream bytes: %0d bytes out, %0d taken, %0d need-data, %0d full",
               packed_bytes.size(), board.seen[ST_BYTE], board.seen[ST_ACCEPTED],
               board.seen[ST_NEED], board.seen[ST_FULL]);
      $display("closing answers: %0d ended, %0d error", board.seen[ST_ENDED],
               board.seen[ST_ERROR]);
      if (board.failures == 0) $display("lzw_variable_width_decoder_top: match");
      else $display("lzw_variable_width_decoder_top: mismatch");
      $finish;
   end
endmodule

FILE: files.f
+incdir+design
design/lzw_pkg.sv
design/lzw_dpath.sv
design/lzw_ctrl.sv
design/lzw_variable_width_decoder_top.sv
dv/testbench.sv
